/* rtl/bdl_pkg.sv */
// Shared types and constants for the debounced button bank.
// No dependencies; every module in rtl/ imports this package.
`timescale 1ns / 1ps

package bdl_pkg;

   localparam int FIELD_W   = 23;
   localparam int TIME_W    = 32;
   localparam int DEB_W     = 16;
   localparam int IDX_W     = 5;
   localparam int CNT_W     = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MOMENTARY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GROUP_A   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GROUP_B   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GROUP_C   = 3'd4;

   localparam logic [DEB_W-1:0]   DEBOUNCE_RESET  = 16'd20;
   localparam logic [FIELD_W-1:0] MOMENTARY_RESET = 23'h0007C0;
   localparam logic [FIELD_W-1:0] GROUP_A_RESET   = 23'h00003F;
   localparam logic [FIELD_W-1:0] GROUP_B_RESET   = 23'h00F800;
   localparam logic [FIELD_W-1:0] GROUP_C_RESET   = 23'h000000;

   typedef struct packed {
      logic chg;
      logic lvl;
   } lane_evt_type;

   typedef struct packed {
      logic [FIELD_W-1:0] chg;
      logic [FIELD_W-1:0] lvl;
   } lane_bus_type;

   typedef struct packed {
      logic [FIELD_W-1:0] momentary;
      logic [FIELD_W-1:0] group_a;
      logic [FIELD_W-1:0] group_b;
      logic [FIELD_W-1:0] group_c;
   } mode_cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]   press_count;
      logic               last_valid;
      logic [IDX_W-1:0]   last_pressed;
      logic [FIELD_W-1:0] state_mask;
      logic               changed;
   } result_type;

endpackage

/* rtl/button_debounce_latch_groups.sv */
// Top level of the debounced button bank: stream ports, register file, lanes and merge.
// Depends on bdl_pkg, bdl_lane and bdl_merge.
`timescale 1ns / 1ps

// One scan word carries every button level and a millisecond timestamp; one result word
// comes back per scan. Each button has its own lane that runs the debounce compare in the
// cycle the scan is taken and registers its event; the merge stage then applies momentary,
// toggle and exclusive-group behaviour to the active state once the output register is
// free and holds the result in the output register. A new scan is taken every cycle while
// the result stream is not stalled, so throughput is one scan per clock. Register writes
// are taken in any cycle and must be made while no scan is in flight.
module button_debounce_latch_groups
   import bdl_pkg::*;
#(
   parameter int NUM_BUTTONS = 23
) (
   input  logic                 clock,
   input  logic                 reset,
   // scan word: [22:0] pressed_levels, [54:23] now_ms, [55] zero
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [55:0]          req_tdata,
   // result word: [0] changed, [23:1] state_mask, [28:24] last_pressed,
   // [29] last_valid, [37:30] press_count, [39:38] zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata
);

   localparam int LANES = (NUM_BUTTONS < FIELD_W) ? NUM_BUTTONS : FIELD_W;

   logic [DEB_W-1:0] debounce_ff;
   logic [DEB_W-1:0] debounce_in;
   mode_cfg_type     mode_ff;
   mode_cfg_type     mode_in;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   logic               out_free;
   logic               advance;
   logic               take;
   logic [FIELD_W-1:0] levels;
   logic [TIME_W-1:0]  now_ms;
   lane_bus_type       lanes;
   result_type         res;

   assign levels     = req_tdata[FIELD_W-1:0];
   assign now_ms     = req_tdata[FIELD_W+TIME_W-1:FIELD_W];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      debounce_in = debounce_ff;
      mode_in     = mode_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DEBOUNCE:  debounce_in       = csr_wdata[DEB_W-1:0];
            REG_MOMENTARY: mode_in.momentary = csr_wdata;
            REG_GROUP_A:   mode_in.group_a   = csr_wdata;
            REG_GROUP_B:   mode_in.group_b   = csr_wdata;
            REG_GROUP_C:   mode_in.group_c   = csr_wdata;
            default: begin
            end
         endcase
      end
      s1_valid_in  = take || (s1_valid_ff && !out_free);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff       <= DEBOUNCE_RESET;
         mode_ff.momentary <= MOMENTARY_RESET;
         mode_ff.group_a   <= GROUP_A_RESET;
         mode_ff.group_b   <= GROUP_B_RESET;
         mode_ff.group_c   <= GROUP_C_RESET;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         debounce_ff  <= debounce_in;
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar i = 0; i < FIELD_W; i++) begin : g_lane
      if (i < LANES) begin : g_on
         lane_evt_type evt;

         bdl_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .load      (take),
            .level     (levels[i]),
            .now_ms    (now_ms),
            .settle_ms (debounce_ff),
            .evt       (evt)
         );

         assign lanes.chg[i] = evt.chg;
         assign lanes.lvl[i] = evt.lvl;
      end else begin : g_off
         assign lanes.chg[i] = 1'b0;
         assign lanes.lvl[i] = 1'b0;
      end
   end

   bdl_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .lanes   (lanes),
      .mode    (mode_ff),
      .res     (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, res.press_count, res.last_valid, res.last_pressed,
                        res.state_mask, res.changed};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_merge_to_out: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> rsp_tvalid)
      else $error("merged scan did not reach the output register");

   a_count_needs_press: assert property (@(posedge clock) disable iff (reset)
      !res.last_valid |-> (res.press_count == '0))
      else $error("press counter moved without any press");

endmodule

/* rtl/bdl_lane.sv */
// One button lane: accepted level, time of last accepted change and the debounce test.
// Depends on bdl_pkg.
`timescale 1ns / 1ps

module bdl_lane
   import bdl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              level,
   input  logic [TIME_W-1:0] now_ms,
   input  logic [DEB_W-1:0]  settle_ms,
   output lane_evt_type      evt
);

   logic              level_ff;
   logic              level_in;
   logic [TIME_W-1:0] stamp_ff;
   logic [TIME_W-1:0] stamp_in;
   lane_evt_type      evt_ff;
   lane_evt_type      evt_in;
   logic [TIME_W-1:0] age;
   logic              take;

   always_comb begin
      age  = now_ms - stamp_ff;
      take = (level != level_ff) && (age >= {{(TIME_W-DEB_W){1'b0}}, settle_ms});
      level_in   = level_ff;
      stamp_in   = stamp_ff;
      evt_in     = evt_ff;
      if (load) begin
         evt_in.chg = take;
         evt_in.lvl = level;
         if (take) begin
            level_in = level;
            stamp_in = now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         stamp_ff <= '0;
      end else begin
         level_ff <= level_in;
         stamp_ff <= stamp_in;
      end
      evt_ff <= evt_in;
   end

   assign evt = evt_ff;

endmodule

/* rtl/bdl_merge.sv */
// Merge stage: folds the lane events of one scan into the active state in index order.
// Depends on bdl_pkg; holds active state, last press and press counter.
`timescale 1ns / 1ps

module bdl_merge
   import bdl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  lane_bus_type lanes,
   input  mode_cfg_type mode,
   output result_type   res
);

   logic [FIELD_W-1:0] act_ff;
   logic [FIELD_W-1:0] act_in;
   logic [IDX_W-1:0]   last_ff;
   logic [IDX_W-1:0]   last_in;
   logic               seen_ff;
   logic               seen_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               changed_ff;
   logic               changed_in;

   logic [FIELD_W-1:0] mom_ev;
   logic [FIELD_W-1:0] press;
   logic [FIELD_W-1:0] any_press;
   logic [FIELD_W-1:0] in_grp;
   logic [FIELD_W-1:0] tog;
   logic [FIELD_W-1:0] grp;
   logic [FIELD_W-1:0] cls_a;
   logic [FIELD_W-1:0] cls_b;
   logic [FIELD_W-1:0] cls_c;
   logic [FIELD_W-1:0] ex;
   logic [FIELD_W-1:0] ex_nx;
   logic [FIELD_W-1:0] lo_m;
   logic [FIELD_W-1:0] hi_m;
   logic [FIELD_W-1:0] clr_pre;
   logic [FIELD_W-1:0] clr_post;
   logic [FIELD_W-1:0] prior;
   logic [IDX_W-1:0]   last_idx;

   always_comb begin
      mom_ev    = lanes.chg & mode.momentary;
      press     = lanes.chg & lanes.lvl & ~mode.momentary;
      any_press = press | (mom_ev & lanes.lvl);
      in_grp    = mode.group_a | mode.group_b | mode.group_c;
      tog       = press & ~in_grp;
      grp       = press & in_grp;
      cls_a     = mode.group_a;
      cls_b     = mode.group_b & ~mode.group_a;
      cls_c     = mode.group_c & ~mode.group_a & ~mode.group_b;

      // a group press takes effect unless its own bit is still set when reached
      ex    = grp & ~act_ff;
      ex_nx = ex;
      for (int r = 0; r < 3; r++) begin
         for (int b = 0; b < FIELD_W; b++) begin
            lo_m     = ~({FIELD_W{1'b1}} << b);
            ex_nx[b] = grp[b] & (~act_ff[b]
                       | (mode.group_a[b] & (|(ex & cls_a & lo_m)))
                       | (mode.group_b[b] & (|(ex & cls_b & lo_m)))
                       | (mode.group_c[b] & (|(ex & cls_c & lo_m))));
         end
         ex = ex_nx;
      end

      for (int b = 0; b < FIELD_W; b++) begin
         lo_m = ~({FIELD_W{1'b1}} << b);
         hi_m = ({FIELD_W{1'b1}} << b) << 1;
         clr_pre[b]  = (mode.group_a[b] & (|(ex & cls_a & lo_m)))
                     | (mode.group_b[b] & (|(ex & cls_b & lo_m)))
                     | (mode.group_c[b] & (|(ex & cls_c & lo_m)));
         clr_post[b] = (mode.group_a[b] & (|(ex & cls_a & hi_m)))
                     | (mode.group_b[b] & (|(ex & cls_b & hi_m)))
                     | (mode.group_c[b] & (|(ex & cls_c & hi_m)));
         prior[b] = act_ff[b] & ~clr_pre[b];
      end

      last_idx = last_ff;
      for (int b = 0; b < FIELD_W; b++) begin
         if (any_press[b]) begin
            last_idx = IDX_W'(b);
         end
      end

      act_in     = act_ff;
      last_in    = last_ff;
      seen_in    = seen_ff;
      count_in   = count_ff;
      changed_in = changed_ff;
      if (advance) begin
         for (int b = 0; b < FIELD_W; b++) begin
            if (clr_post[b]) begin
               act_in[b] = 1'b0;
            end else if (mom_ev[b]) begin
               act_in[b] = lanes.lvl[b];
            end else if (tog[b]) begin
               act_in[b] = ~prior[b];
            end else if (grp[b]) begin
               act_in[b] = 1'b1;
            end else begin
               act_in[b] = prior[b];
            end
         end
         last_in    = last_idx;
         seen_in    = seen_ff | (|any_press);
         count_in   = count_ff + CNT_W'($countones(any_press));
         changed_in = (|mom_ev) | (|press);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff     <= '0;
         last_ff    <= '0;
         seen_ff    <= 1'b0;
         count_ff   <= '0;
         changed_ff <= 1'b0;
      end else begin
         act_ff     <= act_in;
         last_ff    <= last_in;
         seen_ff    <= seen_in;
         count_ff   <= count_in;
         changed_ff <= changed_in;
      end
   end

   assign res.changed      = changed_ff;
   assign res.state_mask   = act_ff;
   assign res.last_pressed = last_ff;
   assign res.last_valid   = seen_ff;
   assign res.press_count  = count_ff;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the debounced button bank: scans in, state reports out,
// each report checked against a cycle-free prediction of debounce, toggle and group rules.
// Depends on bdl_pkg and button_debounce_latch_groups.
`timescale 1ns / 1ps

module tb_top;
   import bdl_pkg::*;

   localparam int NUM_BTN          = 23;
   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 115;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int REPORT_LIMIT     = 10;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED  = 3'd7;
   localparam logic [FIELD_W-1:0]   ALL_BUTTONS = 23'h7FFFFF;

   typedef struct packed {
      logic [TIME_W-1:0]  now;
      logic [FIELD_W-1:0] levels;
   } scan_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [55:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [39:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0]   csr_wdata;

   // predicted block state
   logic [DEB_W-1:0]   cfg_debounce;
   logic [FIELD_W-1:0] cfg_momentary;
   logic [FIELD_W-1:0] cfg_group_a;
   logic [FIELD_W-1:0] cfg_group_b;
   logic [FIELD_W-1:0] cfg_group_c;
   logic [FIELD_W-1:0] held_levels;
   logic [FIELD_W-1:0] latched;
   logic [TIME_W-1:0]  stamp [NUM_BTN];
   logic [IDX_W-1:0]   recent_button;
   logic               recent_seen;
   logic [CNT_W-1:0]   press_tally;

   scan_type   scan_backlog[$];
   result_type button_reports[$];

   int   send_idle_pct;
   int   stall_pct;
   int   error_count;
   int   quiet_cycles;
   logic req_taken;

   logic [FIELD_W-1:0] gen_levels;
   logic [TIME_W-1:0]  gen_now;

   button_debounce_latch_groups #(
      .NUM_BUTTONS(NUM_BTN)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type debounce_scan(input scan_type s);
      result_type         rpt;
      logic [FIELD_W-1:0] lane;
      logic [FIELD_W-1:0] grp;
      logic [TIME_W-1:0]  age;
      logic               any_change;
      any_change = 1'b0;
      for (int i = 0; i < NUM_BTN; i++) begin
         lane = FIELD_W'(1) << i;
         age  = s.now - stamp[i];
         if (s.levels[i] != held_levels[i] && age >= TIME_W'(cfg_debounce)) begin
            stamp[i]       = s.now;
            held_levels[i] = s.levels[i];
            if (cfg_momentary[i] || s.levels[i]) begin
               if (cfg_momentary[i]) begin
                  latched[i] = s.levels[i];
               end else begin
                  grp = cfg_group_a[i] ? cfg_group_a :
                        cfg_group_b[i] ? cfg_group_b :
                        cfg_group_c[i] ? cfg_group_c : '0;
                  if (grp == '0) begin
                     latched[i] = ~latched[i];
                  end else if (!latched[i]) begin
                     latched = (latched & ~grp) | lane;
                  end
               end
               if (s.levels[i]) begin
                  recent_button = IDX_W'(i);
                  recent_seen   = 1'b1;
                  press_tally   = press_tally + CNT_W'(1);
               end
               any_change = 1'b1;
            end
         end
      end
      rpt.changed      = any_change;
      rpt.state_mask   = latched;
      rpt.last_pressed = recent_button;
      rpt.last_valid   = recent_seen;
      rpt.press_count  = press_tally;
      return rpt;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic push_scan(input logic [FIELD_W-1:0] levels, input logic [TIME_W-1:0] now);
      scan_type s;
      s.levels = levels;
      s.now    = now;
      scan_backlog.push_back(s);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // scan word driver and result stall
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (scan_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, scan_backlog.pop_front()};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // monitor: predict on accepted scans, check accepted result words
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (button_reports.size() == 0) begin
               note_error($sformatf("unexpected result word %h", rsp_tdata));
            end else begin
               want = button_reports.pop_front();
               if (got.changed !== want.changed || got.state_mask !== want.state_mask ||
                   got.last_pressed !== want.last_pressed ||
                   got.last_valid !== want.last_valid ||
                   got.press_count !== want.press_count) begin
                  note_error($sformatf({
                     "mismatch at %0t: expected chg=%0d state=%h last=%0d valid=%0d cnt=%0d,",
                     " got chg=%0d state=%h last=%0d valid=%0d cnt=%0d"},
                     $time, want.changed, want.state_mask, want.last_pressed, want.last_valid,
                     want.press_count, got.changed, got.state_mask, got.last_pressed,
                     got.last_valid, got.press_count));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DEBOUNCE:  cfg_debounce  = csr_wdata[DEB_W-1:0];
               REG_MOMENTARY: cfg_momentary = csr_wdata;
               REG_GROUP_A:   cfg_group_a   = csr_wdata;
               REG_GROUP_B:   cfg_group_b   = csr_wdata;
               REG_GROUP_C:   cfg_group_c   = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            button_reports.push_back(debounce_scan(scan_type'(req_tdata[$bits(scan_type)-1:0])));
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int span;
      int r;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = REG_DEBOUNCE;
      csr_wdata     = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      error_count   = 0;
      cfg_debounce  = DEBOUNCE_RESET;
      cfg_momentary = MOMENTARY_RESET;
      cfg_group_a   = GROUP_A_RESET;
      cfg_group_b   = GROUP_B_RESET;
      cfg_group_c   = GROUP_C_RESET;
      held_levels   = '0;
      latched       = '0;
      foreach (stamp[i]) stamp[i] = '0;
      recent_button = '0;
      recent_seen   = 1'b0;
      press_tally   = '0;
      gen_levels    = '0;
      gen_now       = 32'h8000_0020;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: begin
               write_reg(REG_DEBOUNCE, '0);
               write_reg(REG_MOMENTARY, '0);
               write_reg(REG_GROUP_A, '0);
               write_reg(REG_GROUP_B, '0);
               write_reg(REG_GROUP_C, '0);
               write_reg(REG_UNUSED, FIELD_W'($urandom));
            end
            2: begin
               // upper write bits fall outside the debounce field
               write_reg(REG_DEBOUNCE, ALL_BUTTONS);
               write_reg(REG_MOMENTARY, 23'h00F0F0);
               write_reg(REG_GROUP_A, ALL_BUTTONS);
               write_reg(REG_GROUP_B, 23'h00FFFF);
               write_reg(REG_GROUP_C, 23'h0F0000);
            end
            3: begin
               write_reg(REG_DEBOUNCE, FIELD_W'($urandom_range(50)));
               write_reg(REG_MOMENTARY, FIELD_W'($urandom));
               write_reg(REG_GROUP_A, FIELD_W'($urandom));
               write_reg(REG_GROUP_B, ALL_BUTTONS);
               write_reg(REG_GROUP_C, FIELD_W'($urandom));
            end
            4: begin
               write_reg(REG_DEBOUNCE, FIELD_W'($urandom_range(200)));
               write_reg(REG_MOMENTARY, ALL_BUTTONS);
               write_reg(REG_GROUP_A, FIELD_W'($urandom));
               write_reg(REG_GROUP_B, FIELD_W'($urandom));
               write_reg(REG_GROUP_C, FIELD_W'($urandom));
            end
            5: begin
               write_reg(REG_DEBOUNCE, FIELD_W'($urandom_range(1, 30)));
               write_reg(REG_MOMENTARY, FIELD_W'($urandom) & 23'h0000FF);
               write_reg(REG_GROUP_A, 23'h000F00);
               write_reg(REG_GROUP_B, 23'h00F000);
               write_reg(REG_GROUP_C, ALL_BUTTONS);
            end
            default: ;
         endcase

         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 46; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 46; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase

         if (phase == 0) begin
            push_scan(23'h000001, 32'd5);          // too soon after reset
            push_scan(23'h000001, 32'd20);         // group member takes over
            push_scan(23'h000000, 32'd30);         // bounce, held off
            push_scan(23'h000000, 32'd40);         // latching release
            push_scan(23'h000001, 32'd60);         // active member pressed again
            push_scan(23'h000002, 32'd80);         // group switches member
            push_scan(23'h010840, 32'd100);        // momentary, group and toggle
            push_scan(23'h000000, 32'd130);
            push_scan(23'h010000, 32'd150);        // toggle back off
            push_scan(23'h400000, 32'd170);
            push_scan(ALL_BUTTONS, 32'd200);
            push_scan(23'h000000, 32'd230);
            push_scan(ALL_BUTTONS, 32'hFFFF_FFF0);
            push_scan(23'h000000, 32'hFFFF_FFFF);  // held off near wrap
            push_scan(23'h000000, 32'h0000_0004);  // accepted across wrap
            push_scan(23'h555555, 32'h0000_000A);
            push_scan(23'h2AAAAA, 32'h8000_0000);
            push_scan(23'h000000, 32'h8000_0000);
            push_scan(23'h000000, 32'h8000_0014);
         end

         span = int'(cfg_debounce) / 3 + 2;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            r = $urandom_range(99);
            if (r < 5) begin
               gen_now    = $urandom;
               gen_levels = FIELD_W'($urandom);
            end else begin
               gen_now = gen_now + TIME_W'($urandom_range(span));
               if (r < 15) begin
                  gen_levels = FIELD_W'($urandom);
               end else if (r < 85) begin
                  repeat ($urandom_range(1, 3))
                     gen_levels[IDX_W'($urandom_range(NUM_BTN-1))] ^= 1'b1;
               end
            end
            push_scan(gen_levels, gen_now);
         end

         while (scan_backlog.size() != 0 || req_tvalid || button_reports.size() != 0)
            @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      while (button_reports.size() != 0) begin
         void'(button_reports.pop_front());
         note_error("expected result never arrived");
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
